[sv/toeq_pkg.sv]
`default_nettype none
package toeq_pkg;

   localparam int TimeWidth  = 32;
   localparam int IdentWidth = 16;
   localparam int FillWidth  = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [TimeWidth-1:0]  key_time;
      logic                  kind;
      logic [IdentWidth-1:0] ident;
   } sched_event_type;

   // Broadcast from the top level to every cell in the chain.
   typedef struct packed {
      logic            update;
      op_type          op;
      sched_event_type insert_event;
   } cell_ctl_type;

endpackage
`default_nettype wire

[sv/time_ordered_event_queue.sv]
`default_nettype none
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   operation, event_key_time, event_kind, event_ident
// rsp_      out        rsp_valid/rsp_stall   head_valid, head_time, head_kind, head_ident,
//                                            fill_count, status
//
// For each request, every cell of the chain decides in parallel whether
// to hold, take the new event or take a neighbor's entry, and the result register
// loads the new head in the same edge. One request per cycle is accepted while the
// result register is empty or being drained. Reset clears the fill count and the
// result valid; entry contents need no clearing because only filled cells are read.
module time_ordered_event_queue
   import toeq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_operation,
   input  wire logic [TimeWidth-1:0]  req_event_key_time,
   input  wire logic                  req_event_kind,
   input  wire logic [IdentWidth-1:0] req_event_ident,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_head_valid,
   output logic [TimeWidth-1:0]       rsp_head_time,
   output logic                       rsp_head_kind,
   output logic [IdentWidth-1:0]      rsp_head_ident,
   output logic [FillWidth-1:0]       rsp_fill_count,
   output logic [1:0]                 rsp_status
);

   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  accept;
   logic                  is_full, is_empty;
   status_type            status;
   cell_ctl_type          ctl;

   sched_event_type       entry    [DEPTH];
   sched_event_type       entry_in [DEPTH];
   logic                  keep     [DEPTH];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  head_valid_ff, head_valid_in;
   sched_event_type       head_ff, head_in;
   logic [CountWidth-1:0] fill_ff;
   status_type            status_ff;
   logic [CountWidth+FillWidth-1:0] fill_wide;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_full  = (count_ff == CountWidth'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      status   = ST_OK;
      count_in = count_ff;
      if (accept) begin
         if (op_type'(req_operation) == OP_INSERT) begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   always_comb begin
      ctl.update                = accept && (status == ST_OK);
      ctl.op                    = op_type'(req_operation);
      ctl.insert_event.key_time = req_event_key_time;
      ctl.insert_event.kind     = req_event_kind;
      ctl.insert_event.ident    = req_event_ident;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic            occupied;
      logic            prev_keep;
      sched_event_type prev_entry;
      sched_event_type next_entry;

      assign occupied = (count_ff > CountWidth'(i));

      if (i == 0) begin : g_first
         // On insert, the head cell takes the new event whenever it does not keep its own.
         assign prev_keep  = 1'b1;
         assign prev_entry = ctl.insert_event;
      end else begin : g_rest
         assign prev_keep  = keep[i-1];
         assign prev_entry = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_entry = entry[i];
      end else begin : g_inner
         assign next_entry = entry[i+1];
      end

      toeq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occupied),
         .prev_keep  (prev_keep),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entry[i]),
         .entry_in   (entry_in[i]),
         .keep       (keep[i])
      );
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      head_valid_in = (count_in != '0);
      head_in       = '0;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
      if (head_valid_in) begin
         head_in = entry_in[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         head_valid_ff <= head_valid_in;
         head_ff       <= head_in;
         fill_ff       <= count_in;
         status_ff     <= status;
      end
   end

   assign fill_wide = {{FillWidth{1'b0}}, fill_ff};

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_valid = head_valid_ff;
   assign rsp_head_time  = head_ff.key_time;
   assign rsp_head_kind  = head_ff.kind;
   assign rsp_head_ident = head_ff.ident;
   assign rsp_fill_count = fill_wide[FillWidth-1:0];
   assign rsp_status     = status_ff;

endmodule
`default_nettype wire

[sv/toeq_cell.sv]
`default_nettype none
module toeq_cell
   import toeq_pkg::*;
(
   input  wire logic            clock,
   input  wire cell_ctl_type    ctl,
   input  wire logic            occupied,
   input  wire logic            prev_keep,
   input  wire sched_event_type prev_entry,
   input  wire sched_event_type next_entry,
   output sched_event_type      entry,
   output sched_event_type      entry_in,
   output logic                 keep
);

   sched_event_type entry_ff;

   // A cell keeps its entry on insert when the new event sorts behind it,
   // so equal timestamps stay in arrival order.
   assign keep = occupied && !(ctl.insert_event.key_time < entry_ff.key_time);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.update) begin
         case (ctl.op)
            OP_INSERT: begin
               if (keep) begin
                  entry_in = entry_ff;
               end else if (prev_keep) begin
                  entry_in = ctl.insert_event;
               end else begin
                  entry_in = prev_entry;
               end
            end
            OP_REMOVE: begin
               entry_in = next_entry;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

[tb/sv/tb_time_ordered_event_queue.sv]
`timescale 1ns / 1ps

module tb_time_ordered_event_queue
   import toeq_pkg::*;
();

   localparam int QueueDepth     = 16;
   localparam int RandomRequests = 1525;
   localparam int IdleLimit      = 2000;
   localparam int HoldOffCycles  = 60;
   localparam int SettleCycles   = 20;

   typedef struct packed {
      logic                  head_valid;
      logic [TimeWidth-1:0]  head_time;
      logic                  head_kind;
      logic [IdentWidth-1:0] head_ident;
      logic [FillWidth-1:0]  fill_count;
      status_type            status;
   } head_report_type;

   typedef struct packed {
      op_type          op;
      sched_event_type ev;
      logic            drain_first;
   } queued_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_operation = 1'b0;
   logic [TimeWidth-1:0]  req_event_key_time = '0;
   logic                  req_event_kind = 1'b0;
   logic [IdentWidth-1:0] req_event_ident = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_head_valid;
   logic [TimeWidth-1:0]  rsp_head_time;
   logic                  rsp_head_kind;
   logic [IdentWidth-1:0] rsp_head_ident;
   logic [FillWidth-1:0]  rsp_fill_count;
   logic [1:0]            rsp_status;

   queued_request_type pending_requests[$];
   head_report_type    expected_heads[$];

   // Sorted copy of the event list, earliest event at index zero.
   sched_event_type model_entries[QueueDepth];
   int              model_count = 0;

   int error_count = 0;
   int heads_checked = 0;
   int idle_cycles = 0;

   int gap_left = 0;
   int burst_left = 0;
   int hold_left = 0;
   int holds_done = 0;
   int stall_percent = 0;
   int pattern_left = 0;

   time_ordered_event_queue #(
      .DEPTH(QueueDepth)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_event_key_time (req_event_key_time),
      .req_event_kind     (req_event_kind),
      .req_event_ident    (req_event_ident),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_head_valid     (rsp_head_valid),
      .rsp_head_time      (rsp_head_time),
      .rsp_head_kind      (rsp_head_kind),
      .rsp_head_ident     (rsp_head_ident),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_status         (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic head_report_type apply_to_event_list(op_type op, sched_event_type ev);
      head_report_type report;
      int pos;
      report = '0;
      report.status = ST_OK;
      if (op == OP_INSERT) begin
         if (model_count >= QueueDepth) begin
            report.status = ST_FULL;
         end else begin
            // A new event goes behind every stored event with the same time.
            pos = 0;
            while (pos < model_count && !(ev.key_time < model_entries[pos].key_time))
               pos++;
            for (int i = model_count; i > pos; i--)
               model_entries[i] = model_entries[i-1];
            model_entries[pos] = ev;
            model_count++;
         end
      end else if (model_count == 0) begin
         report.status = ST_EMPTY;
      end else begin
         for (int i = 1; i < model_count; i++)
            model_entries[i-1] = model_entries[i];
         model_count--;
      end
      if (model_count > 0) begin
         report.head_valid = 1'b1;
         report.head_time  = model_entries[0].key_time;
         report.head_kind  = model_entries[0].kind;
         report.head_ident = model_entries[0].ident;
      end
      report.fill_count = FillWidth'(model_count);
      return report;
   endfunction

   function automatic logic [TimeWidth-1:0] pick_event_time();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
         // Few distinct whole-unit times, so equal timestamps are common.
         return {16'($urandom_range(0, 7)), 16'h0000};
      end else if (sel == 3) begin
         case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_FFFF;
            default: return 32'h0001_0000;
         endcase
      end
      return $urandom;
   endfunction

   task automatic queue_request(op_type op, logic [TimeWidth-1:0] key_time, logic kind,
                                logic [IdentWidth-1:0] ident, logic drain_first);
      queued_request_type item;
      item.op          = op;
      item.ev.key_time = key_time;
      item.ev.kind     = kind;
      item.ev.ident    = ident;
      item.drain_first = drain_first;
      pending_requests = {pending_requests, item};
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      queued_request_type item;
      sched_event_type    ev;
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   = 0;
         burst_left = $urandom_range(1, 40);
      end else begin
         if (req_valid && !req_stall) begin
            ev.key_time = req_event_key_time;
            ev.kind     = req_event_kind;
            ev.ident    = req_event_ident;
            expected_heads = {expected_heads,
                              apply_to_event_list(op_type'(req_operation), ev)};
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain_first && expected_heads.size() != 0)) begin
               item = pending_requests.pop_front();
               req_operation      <= item.op;
               req_event_key_time <= item.ev.key_time;
               req_event_kind     <= item.ev.kind;
               req_event_ident    <= item.ev.ident;
               req_valid          <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: a stall rate that changes every so often, plus two long
   // hold-offs that let the block back up and stall its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_done < 2 && heads_checked >= 400 * (holds_done + 1)) begin
            hold_left = HoldOffCycles;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 3))
                  0: stall_percent = 0;
                  1: stall_percent = 25;
                  2: stall_percent = 50;
                  default: stall_percent = 75;
               endcase
               pattern_left = $urandom_range(16, 128);
            end
            pattern_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_percent);
         end
      end
   end

   always @(posedge clock) begin
      head_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_heads.size() == 0) begin
            $display("%0t: result with no request outstanding, actual head %0h fill %0d",
                     $time, rsp_head_time, rsp_fill_count);
            error_count++;
         end else begin
            want = expected_heads.pop_front();
            check_field("head_valid", want.head_valid, rsp_head_valid);
            check_field("head_time", want.head_time, rsp_head_time);
            check_field("head_kind", want.head_kind, rsp_head_kind);
            check_field("head_ident", want.head_ident, rsp_head_ident);
            check_field("fill_count", want.fill_count, rsp_fill_count);
            check_field("status", want.status, rsp_status);
         end
         heads_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == IdleLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int random_count;
      int phase_length;
      int insert_percent;
      op_type op;

      // Remove from an empty queue, then extremes of every field.
      queue_request(OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
      queue_request(OP_INSERT, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
      queue_request(OP_INSERT, 32'h0000_0000, 1'b0, 16'h0000, 1'b0);
      // Equal timestamps must leave in arrival order.
      queue_request(OP_INSERT, 32'h0001_8000, 1'b0, 16'h0101, 1'b0);
      queue_request(OP_INSERT, 32'h0001_8000, 1'b1, 16'h0202, 1'b0);
      queue_request(OP_INSERT, 32'h0001_8000, 1'b0, 16'h0303, 1'b0);
      queue_request(OP_INSERT, 32'hFFFF_FFFF, 1'b0, 16'hAAAA, 1'b0);
      queue_request(OP_INSERT, 32'h0000_0000, 1'b1, 16'h5555, 1'b0);
      queue_request(OP_INSERT, 32'h7FFF_FFFF, 1'b1, 16'h8000, 1'b0);
      repeat (9) queue_request(OP_REMOVE, $urandom, 1'($urandom_range(0, 1)),
                               16'($urandom_range(0, 65535)), 1'b0);

      // Random phases that lean toward filling, toward draining or neither, so the
      // queue keeps running into full and empty.
      random_count = 0;
      while (random_count < RandomRequests) begin
         case ($urandom_range(0, 2))
            0: insert_percent = 85;
            1: insert_percent = 15;
            default: insert_percent = 50;
         endcase
         phase_length = $urandom_range(10, 60);
         if (random_count == 0) begin
            insert_percent = 100;
            phase_length   = 20;
         end
         repeat (phase_length) begin
            op = ($urandom_range(0, 99) < insert_percent) ? OP_INSERT : OP_REMOVE;
            queue_request(op, pick_event_time(), 1'($urandom_range(0, 1)),
                          16'($urandom_range(0, 65535)),
                          random_count == 700 || random_count == 1300);
            random_count++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_heads.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
